// File: hw/rtl/givens_rotation_generator_assert.svh
// Assertion macros shared by the Givens rotation generator modules.
`ifndef GIVENS_ROTATION_GENERATOR_ASSERT_SVH
`define GIVENS_ROTATION_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GRG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GRG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/grg_pkg.sv
// Package: widths, constants, types and step functions of the rotation generator.
`timescale 1ns / 1ps
package grg_pkg;

  localparam int FRAC   = 30;
  localparam int IN_W   = 32;
  localparam int CS_W   = 32;
  localparam int XI_W   = 48;
  localparam int ONE_W  = FRAC + 1;
  localparam int REM_W  = 2 * FRAC + 2;
  localparam int DEN_W  = XI_W;
  localparam int ACC_W  = XI_W - 1;
  localparam int XI_INT = XI_W - 1 - FRAC;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [ONE_W-1:0] ONE    = {1'b1, {FRAC{1'b0}}};
  localparam logic [REM_W-1:0] ONE_SQ = REM_W'(1) << (2 * FRAC);
  localparam logic [XI_W-1:0]  XI_MAX = {1'b0, {(XI_W-1){1'b1}}};

  localparam logic CMD_FIND   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef enum logic [2:0] {
    CL_ZERO,
    CL_A_DOM,
    CL_B_DOM,
    CL_DEC_SMALL,
    CL_DEC_ONE,
    CL_DEC_SAT,
    CL_DEC_DIV
  } cls_t;

  // queue word from front to back
  typedef struct packed {
    cls_t               cls;
    logic               neg;
    logic               one;
    logic [DEN_W-1:0]   num;
    logic [DEN_W-1:0]   den;
    logic [ONE_W-1:0]   xmag;
  } job_t;

  // pipeline word; rem/acc serve every divide and root phase, den only the divides
  typedef struct packed {
    cls_t               cls;
    logic               neg;
    logic               sat;
    logic [ONE_W-1:0]   t;
    logic [ONE_W-1:0]   r;
    logic [ONE_W-1:0]   v;
    logic [ONE_W-1:0]   u;
    logic [DEN_W-1:0]   den;
    logic [REM_W-1:0]   rem;
    logic [ACC_W-1:0]   acc;
  } pipe_t;

  // one restoring-division step, shifting in bit b
  function automatic pipe_t div_step(pipe_t p, logic b);
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] dx;
    pipe_t            o;
    o     = p;
    sh    = {p.rem[REM_W-2:0], b};
    dx    = REM_W'(p.den);
    o.acc = {p.acc[ACC_W-2:0], 1'b0};
    if (sh >= dx) begin
      o.rem    = sh - dx;
      o.acc[0] = 1'b1;
    end else begin
      o.rem = sh;
    end
    return o;
  endfunction

  // one digit-by-digit square root step for result bit i
  function automatic pipe_t sqrt_step(pipe_t p, int i);
    logic [REM_W-1:0] trial;
    pipe_t            o;
    o     = p;
    trial = (REM_W'(p.acc) << (i + 1)) | (REM_W'(1) << (2 * i));
    if (p.rem >= trial) begin
      o.rem = p.rem - trial;
      o.acc = p.acc | (ACC_W'(1) << i);
    end
    return o;
  endfunction

endpackage

// File: hw/rtl/grg_in_if.sv
// Input channel interface: command and operands.
`timescale 1ns / 1ps
interface grg_in_if import grg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic signed [IN_W-1:0] a_val;
  logic signed [IN_W-1:0] b_val;
  logic signed [XI_W-1:0] xi_in;

  modport source (output valid, command, a_val, b_val, xi_in, input ready);
  modport sink   (input valid, command, a_val, b_val, xi_in, output ready);
endinterface

// Result channel interface: cosine, sine and compact code.
interface grg_out_if import grg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [CS_W-1:0] c_out;
  logic signed [CS_W-1:0] s_out;
  logic signed [XI_W-1:0] xi_out;

  modport source (output valid, c_out, s_out, xi_out, input ready);
  modport sink   (input valid, c_out, s_out, xi_out, output ready);
endinterface

// File: hw/rtl/grg_front.sv
// Front stage: takes input words, forms magnitudes and classifies the case.
`timescale 1ns / 1ps
module grg_front import grg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  grg_in_if.sink in_ch,
  output job_t  job_o,
  output logic  job_vld_o,
  input  logic  job_rdy_i
);

  job_t             job_r;
  job_t             job_nxt;
  logic             vld_r;
  logic [IN_W-1:0]  am;
  logic [IN_W-1:0]  bm;
  logic [XI_W-1:0]  xm;

  assign in_ch.ready = !vld_r || job_rdy_i;
  assign job_o       = job_r;
  assign job_vld_o   = vld_r;

  always_comb begin
    am = in_ch.a_val[IN_W-1] ? IN_W'(~in_ch.a_val + 1'b1) : IN_W'(in_ch.a_val);
    bm = in_ch.b_val[IN_W-1] ? IN_W'(~in_ch.b_val + 1'b1) : IN_W'(in_ch.b_val);
    xm = in_ch.xi_in[XI_W-1] ? XI_W'(~in_ch.xi_in + 1'b1) : XI_W'(in_ch.xi_in);
    job_nxt       = '0;
    if (in_ch.command == CMD_FIND) begin
      job_nxt.neg = in_ch.a_val[IN_W-1] ^ in_ch.b_val[IN_W-1];
      if (am == '0 && bm == '0) begin
        job_nxt.cls = CL_ZERO;
      end else if (am >= bm) begin
        job_nxt.cls = CL_A_DOM;
        job_nxt.num = DEN_W'(bm);
        job_nxt.den = DEN_W'(am);
      end else begin
        job_nxt.cls = CL_B_DOM;
        job_nxt.num = DEN_W'(am);
        job_nxt.den = DEN_W'(bm);
      end
    end else begin
      job_nxt.neg = in_ch.xi_in[XI_W-1];
      if (xm < XI_W'(ONE)) begin
        job_nxt.cls  = CL_DEC_SMALL;
        job_nxt.xmag = xm[ONE_W-1:0];
      end else if (!in_ch.xi_in[XI_W-1] && xm == XI_W'(ONE)) begin
        job_nxt.cls = CL_DEC_ONE;
      end else if (xm >= XI_MAX) begin
        job_nxt.cls = CL_DEC_SAT;
      end else begin
        job_nxt.cls = CL_DEC_DIV;
        job_nxt.num = DEN_W'(ONE);
        job_nxt.den = xm;
      end
    end
    // quotient saturates to ONE when it would reach or pass one
    job_nxt.one = (job_nxt.den == '0) || (job_nxt.num >= job_nxt.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      job_r <= job_nxt;
    end
  end

endmodule

// File: hw/rtl/grg_fifo.sv
// Short queue between front and back.
`timescale 1ns / 1ps
`include "givens_rotation_generator_assert.svh"
module grg_fifo import grg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  job_t push_data_i,
  input  logic push_i,
  output logic rdy_o,
  output job_t pop_data_o,
  output logic vld_o,
  input  logic pop_i
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push;
  logic              pop;

  assign rdy_o      = count_r != (QPTR_W + 1)'(QDEPTH);
  assign vld_o      = count_r != '0;
  assign pop_data_o = mem_r[rd_ptr_r];
  assign push       = push_i && rdy_o;
  assign pop        = pop_i && vld_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  `GRG_ASSERT_IMP(a_cnt_bound, 1'b1, count_r <= (QPTR_W + 1)'(QDEPTH), "queue count over depth")
  `GRG_ASSERT_NXT(a_cnt_inc, push && !pop, count_r == $past(count_r) + 1'b1, "count missed push")
  `GRG_ASSERT_NXT(a_cnt_dec, pop && !push, count_r == $past(count_r) - 1'b1, "count missed pop")

endmodule

// File: hw/rtl/grg_back.sv
// Back end: bit-per-stage dividers and square roots, result assembly and output register.
`timescale 1ns / 1ps
`include "givens_rotation_generator_assert.svh"
module grg_back import grg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      job_i,
  input  logic      job_vld_i,
  output logic      pop_o,
  grg_out_if.source out_ch
);

  // stage map: ratio divide, square+add, root, v divide, square+sub, root, xi divide
  localparam int SQ1_K  = FRAC;
  localparam int S1_BEG = SQ1_K + 1;
  localparam int S1_END = S1_BEG + ONE_W;
  localparam int D2_BEG = S1_END + 1;
  localparam int D2_END = D2_BEG + FRAC;
  localparam int S2_BEG = D2_END + 1;
  localparam int S2_END = S2_BEG + ONE_W;
  localparam int X_BEG  = S2_END + 1;
  localparam int NST    = X_BEG + ACC_W;

  pipe_t            p_r [0:NST];
  pipe_t            p0_nxt;
  logic [NST:0]     vld_r;
  logic             advance;
  logic             out_vld_r;
  logic [CS_W-1:0]  c_r;
  logic [CS_W-1:0]  s_r;
  logic [XI_W-1:0]  xi_r;
  logic [CS_W-1:0]  c_nxt;
  logic [CS_W-1:0]  s_nxt;
  logic [XI_W-1:0]  xi_nxt;
  logic [XI_W-1:0]  xim;
  pipe_t            pl;

  function automatic logic [CS_W-1:0] sgn_cs(logic n, logic [ONE_W-1:0] m);
    logic [CS_W-1:0] e;
    e = CS_W'(m);
    return n ? (~e + 1'b1) : e;
  endfunction

  function automatic logic [XI_W-1:0] sgn_xi(logic n, logic [XI_W-1:0] m);
    return n ? (~m + 1'b1) : m;
  endfunction

  assign advance      = !out_vld_r || out_ch.ready;
  assign pop_o        = advance && job_vld_i;
  assign out_ch.valid = out_vld_r;
  assign out_ch.c_out = c_r;
  assign out_ch.s_out = s_r;
  assign out_ch.xi_out = xi_r;

  always_comb begin
    p0_nxt     = '0;
    p0_nxt.cls = job_i.cls;
    p0_nxt.neg = job_i.neg;
    p0_nxt.sat = job_i.one;
    p0_nxt.v   = job_i.xmag;
    p0_nxt.den = job_i.den;
    p0_nxt.rem = REM_W'(job_i.num);
  end

  always_ff @(posedge clk) begin
    if (advance) p_r[0] <= p0_nxt;
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    pipe_t            nx;
    if (k < SQ1_K) begin : g_div1
      assign nx = div_step(p_r[k], 1'b0);
    end else if (k == SQ1_K) begin : g_sq1
      logic [ONE_W-1:0]   tv;
      logic [REM_W-1:0]   sq;
      always_comb begin
        nx     = p_r[k];
        tv     = p_r[k].sat ? ONE : p_r[k].acc[ONE_W-1:0];
        sq     = REM_W'(tv) * REM_W'(tv);
        nx.t   = tv;
        nx.rem = ONE_SQ + sq;
        nx.acc = '0;
      end
    end else if (k < S1_END) begin : g_rt1
      assign nx = sqrt_step(p_r[k], S1_END - 1 - k);
    end else if (k == S1_END) begin : g_div2_set
      always_comb begin
        nx     = p_r[k];
        nx.r   = p_r[k].acc[ONE_W-1:0];
        nx.rem = REM_W'(p_r[k].t);
        nx.den = DEN_W'(p_r[k].acc[ONE_W-1:0]);
        nx.acc = '0;
      end
    end else if (k < D2_END) begin : g_div2
      assign nx = div_step(p_r[k], 1'b0);
    end else if (k == D2_END) begin : g_sq2
      logic [ONE_W-1:0]   xv;
      logic [REM_W-1:0]   sq;
      always_comb begin
        nx = p_r[k];
        if (p_r[k].cls inside {CL_ZERO, CL_A_DOM, CL_B_DOM}) begin
          nx.v = p_r[k].acc[ONE_W-1:0];
        end
        xv     = (p_r[k].cls == CL_DEC_DIV) ? p_r[k].t : nx.v;
        sq     = REM_W'(xv) * REM_W'(xv);
        nx.rem = ONE_SQ - sq;
        nx.acc = '0;
      end
    end else if (k < S2_END) begin : g_rt2
      assign nx = sqrt_step(p_r[k], S2_END - 1 - k);
    end else if (k == S2_END) begin : g_xi_set
      always_comb begin
        nx     = p_r[k];
        nx.u   = p_r[k].acc[ONE_W-1:0];
        // integer part of r/t would pass the code range
        nx.sat = (p_r[k].t == '0) ||
                 ({{XI_INT{1'b0}}, p_r[k].r} >= {p_r[k].t, {XI_INT{1'b0}}});
        nx.rem = REM_W'(p_r[k].r >> XI_INT);
        nx.den = DEN_W'(p_r[k].t);
        nx.acc = '0;
      end
    end else begin : g_xi
      localparam int POS = ACC_W - 1 - (k - X_BEG);
      if (POS >= FRAC) begin : g_hi
        assign nx = div_step(p_r[k], p_r[k].r[POS-FRAC]);
      end else begin : g_lo
        assign nx = div_step(p_r[k], 1'b0);
      end
    end

    always_ff @(posedge clk) begin
      if (advance) p_r[k+1] <= nx;
    end
  end

  always_comb begin
    pl     = p_r[NST];
    xim    = pl.sat ? XI_MAX : {1'b0, pl.acc};
    c_nxt  = '0;
    s_nxt  = '0;
    xi_nxt = '0;
    case (pl.cls)
      CL_ZERO: begin
        c_nxt = CS_W'(ONE);
      end
      CL_A_DOM: begin
        c_nxt  = CS_W'(pl.u);
        s_nxt  = sgn_cs(!pl.neg, pl.v);
        xi_nxt = sgn_xi(pl.neg, XI_W'(pl.v));
      end
      CL_B_DOM: begin
        c_nxt  = sgn_cs(pl.neg, pl.v);
        s_nxt  = sgn_cs(1'b1, pl.u);
        xi_nxt = sgn_xi(pl.neg, xim);
      end
      CL_DEC_SMALL: begin
        c_nxt = CS_W'(pl.u);
        s_nxt = sgn_cs(!pl.neg, pl.v);
      end
      CL_DEC_ONE: begin
        c_nxt = CS_W'(ONE);
      end
      CL_DEC_SAT: begin
        s_nxt = sgn_cs(1'b1, ONE);
      end
      CL_DEC_DIV: begin
        c_nxt = sgn_cs(pl.neg, pl.t);
        s_nxt = sgn_cs(1'b1, pl.u);
      end
      default: begin
        c_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      vld_r     <= {vld_r[NST-1:0], job_vld_i};
      out_vld_r <= vld_r[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_r  <= c_nxt;
      s_r  <= s_nxt;
      xi_r <= xi_nxt;
    end
  end

  `GRG_ASSERT_NXT(a_pop_enters, job_vld_i && advance, vld_r[0], "popped word not in pipe")
  `GRG_ASSERT_NXT(a_stall_freeze, out_vld_r && !out_ch.ready, $stable(vld_r), "pipe moved in stall")
  `GRG_ASSERT_NXT(a_tail_out, vld_r[NST] && advance, out_vld_r, "finished word lost at output")

endmodule

// File: hw/rtl/givens_rotation_generator.sv
// Top level of the Givens rotation generator.
//
//   channel   dir  handshake          word
//   in_ch     in   valid/ready        command, a_val, b_val, xi_in
//   out_ch    out  valid/ready        c_out, s_out, xi_out
//
// One word per cycle sustained while out_ch is ready; the back pipeline is a
// chain of one-bit-per-stage dividers and square roots.
// rst_n is synchronous and clears handshake, valid and queue pointer state only.
// A stalled out_ch freezes the back pipeline; the front register and a 4-word
// queue keep taking input until they fill.
`timescale 1ns / 1ps
module givens_rotation_generator import grg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  grg_in_if.sink     in_ch,
  grg_out_if.source  out_ch
);

  job_t front_job;
  logic front_vld;
  logic q_rdy;
  job_t q_job;
  logic q_vld;
  logic q_pop;

  grg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_o     (front_job),
    .job_vld_o (front_vld),
    .job_rdy_i (q_rdy)
  );

  grg_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_data_i (front_job),
    .push_i      (front_vld),
    .rdy_o       (q_rdy),
    .pop_data_o  (q_job),
    .vld_o       (q_vld),
    .pop_i       (q_pop)
  );

  grg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_i     (q_job),
    .job_vld_i (q_vld),
    .pop_o     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

// File: tb/tb_givens_rotation_generator.sv
// Testbench for the Givens rotation generator: random and directed find/decode words.
`timescale 1ns / 1ps
module tb_givens_rotation_generator;
  import grg_pkg::*;

  localparam longint unsigned ONE_V = 64'd1 << FRAC;
  localparam longint unsigned XMAX  = (64'd1 << (XI_W - 1)) - 1;
  localparam longint unsigned LIMIT = 64'd3000000;

  typedef struct {
    logic                   command;
    logic signed [IN_W-1:0] a_val;
    logic signed [IN_W-1:0] b_val;
    logic signed [XI_W-1:0] xi_in;
  } rot_req_t;

  typedef struct {
    logic signed [CS_W-1:0] c;
    logic signed [CS_W-1:0] s;
    logic signed [XI_W-1:0] xi;
  } rot_res_t;

  logic clk, rst_n;
  grg_in_if  in_ch();
  grg_out_if out_ch();

  givens_rotation_generator dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  rot_req_t pending_q[$];
  rot_res_t expected_q[$];
  int       errors;
  int       n_sent, n_got, n_find, n_dec;
  int       send_idle_pct, recv_stall_pct;
  longint unsigned cycles;

  // 128-bit helpers for the exact math
  function automatic logic [127:0] isqrt128(logic [127:0] n);
    logic [127:0] res, cand;
    res = 0;
    for (int i = 63; i >= 0; i--) begin
      cand = res | (128'd1 << i);
      if (cand * cand <= n) res = cand;
    end
    return res;
  endfunction

  function automatic longint unsigned ratio_q(longint unsigned num, longint unsigned den);
    logic [127:0] q;
    if (den == 0 || num >= den) return ONE_V;
    q = ({64'd0, num} << FRAC) / den;
    return q[63:0];
  endfunction

  function automatic longint unsigned unit_root(longint unsigned x);
    logic [127:0] o;
    if (x > ONE_V) x = ONE_V;
    o = ({64'd0, ONE_V} * ONE_V) - ({64'd0, x} * x);
    return 64'(isqrt128(o));
  endfunction

  function automatic longint unsigned hyp_root(longint unsigned t);
    return 64'(isqrt128(({64'd0, ONE_V} * ONE_V) + ({64'd0, t} * t)));
  endfunction

  function automatic longint unsigned magnitude(logic signed [63:0] x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic rot_res_t rotation_of(rot_req_t q);
    rot_res_t o;
    longint unsigned am, bm, t, r, v, cm, sm, xm, mag;
    logic an, bn, sg, cn, sn, xn;
    logic [127:0] w;
    cn = 0; sn = 0; xn = 0; xm = 0;
    if (q.command == CMD_FIND) begin
      an = q.a_val[IN_W-1]; bn = q.b_val[IN_W-1];
      am = magnitude(64'(q.a_val)); bm = magnitude(64'(q.b_val));
      sg = an ^ bn;
      if (am == 0 && bm == 0) begin
        cm = ONE_V; sm = 0;
      end else if (am >= bm) begin
        t = ratio_q(bm, am); r = hyp_root(t); v = ratio_q(t, r);
        cm = unit_root(v); sm = v; sn = !sg; xm = v; xn = sg;
      end else begin
        t = ratio_q(am, bm); r = hyp_root(t); v = ratio_q(t, r);
        cm = v; cn = sg; sm = unit_root(v); sn = 1; xn = sg;
        if (t == 0) xm = XMAX;
        else begin
          w = ({64'd0, r} << FRAC) / t;
          xm = (w > XMAX) ? XMAX : w[63:0];
        end
      end
    end else begin
      xn = 0;
      mag = magnitude(64'(q.xi_in));
      if (mag < ONE_V) begin
        cm = unit_root(mag); sm = mag; sn = !q.xi_in[XI_W-1];
      end else if (!q.xi_in[XI_W-1] && mag == ONE_V) begin
        cm = ONE_V; sm = 0;
      end else if (mag >= XMAX) begin
        cm = 0; sm = ONE_V; sn = 1;
      end else begin
        cm = ratio_q(ONE_V, mag); cn = q.xi_in[XI_W-1];
        sm = unit_root(cm); sn = 1;
      end
    end
    o.c  = cn ? -CS_W'(cm) : CS_W'(cm);
    o.s  = sn ? -CS_W'(sm) : CS_W'(sm);
    o.xi = xn ? -XI_W'(xm) : XI_W'(xm);
    return o;
  endfunction

  function automatic logic signed [IN_W-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return IN_W'($urandom_range(0, 3)) - 1;
      1: return {1'b1, {(IN_W-1){1'b0}}};
      2: return $signed(IN_W'($urandom_range(0, 255))) - 128;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [XI_W-1:0] rand_code();
    logic signed [XI_W-1:0] x;
    x = XI_W'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: return x >>> $urandom_range(17, 40);
      1: return x >>> $urandom_range(1, 16);
      2: return $urandom_range(0, 1) ? XI_W'(ONE_V) : -XI_W'(ONE_V);
      default: return x;
    endcase
  endfunction

  task automatic queue_find(logic signed [IN_W-1:0] a, logic signed [IN_W-1:0] b);
    rot_req_t q;
    q.command = CMD_FIND; q.a_val = a; q.b_val = b; q.xi_in = XI_W'({$urandom, $urandom});
    pending_q.push_back(q);
  endtask

  task automatic queue_decode(logic signed [XI_W-1:0] x);
    rot_req_t q;
    q.command = CMD_DECODE; q.xi_in = x; q.a_val = $urandom; q.b_val = $urandom;
    pending_q.push_back(q);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(rotation_of('{in_ch.command, in_ch.a_val, in_ch.b_val,
                                           in_ch.xi_in}));
        n_sent++;
        if (in_ch.command == CMD_FIND) n_find++; else n_dec++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          rot_req_t q;
          q = pending_q.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.command <= q.command;
          in_ch.a_val   <= q.a_val;
          in_ch.b_val   <= q.b_val;
          in_ch.xi_in   <= q.xi_in;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        rot_res_t e;
        n_got++;
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.c_out !== e.c) begin
            $error("c_out expected %0d actual %0d", e.c, out_ch.c_out); errors++;
          end
          if (out_ch.s_out !== e.s) begin
            $error("s_out expected %0d actual %0d", e.s, out_ch.s_out); errors++;
          end
          if (out_ch.xi_out !== e.xi) begin
            $error("xi_out expected %0d actual %0d", e.xi, out_ch.xi_out); errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout with %0d words outstanding", expected_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic signed [IN_W-1:0] mn, mx;
    int ph_idle[4], ph_stall[4];
    mn = {1'b1, {(IN_W-1){1'b0}}};
    mx = {1'b0, {(IN_W-1){1'b1}}};
    ph_idle  = '{0, 66, 0, 26};
    ph_stall = '{0, 0, 66, 26};
    errors = 0; n_sent = 0; n_got = 0; n_find = 0; n_dec = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_n = 0;
    in_ch.valid = 0; in_ch.command = 0; in_ch.a_val = 0; in_ch.b_val = 0; in_ch.xi_in = 0;
    out_ch.ready = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // directed: zeros, extremes, dominance ties, decode edge codes
    queue_find(0, 0);
    queue_find(0, 5);
    queue_find(0, mn);
    queue_find(7, 0);
    queue_find(mn, mn);
    queue_find(mx, mx);
    queue_find(mx, mn);
    queue_find(mn, 1);
    queue_find(1, mn);
    queue_find(1, mx);
    queue_find(-1, -1);
    queue_find(3, -4);
    queue_find(-4, 3);
    queue_decode('0);
    queue_decode(XI_W'(ONE_V));
    queue_decode(-XI_W'(ONE_V));
    queue_decode(XI_W'(ONE_V) - 1);
    queue_decode(-XI_W'(ONE_V) + 1);
    queue_decode(XI_W'(XMAX));
    queue_decode(-XI_W'(XMAX));
    queue_decode({1'b1, {(XI_W-1){1'b0}}});
    queue_decode(XI_W'(XMAX) - 1);
    queue_decode(XI_W'(ONE_V) + 1);
    queue_decode({XI_W{1'b1}});

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = ph_idle[ph]; recv_stall_pct = ph_stall[ph];
      for (int i = 0; i < 400; i++)
        if ($urandom_range(0, 1)) queue_find(rand_operand(), rand_operand());
        else queue_decode(rand_code());
      wait (pending_q.size() == 0);
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    wait (pending_q.size() == 0 && !in_ch.valid && expected_q.size() == 0);
    repeat (400) @(posedge clk);

    $display("sent %0d words (%0d find, %0d decode), checked %0d results",
             n_sent, n_find, n_dec, n_got);
    $display("idle mixes: none, sender, receiver, both");
    if (errors == 0 && expected_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/grg_pkg.sv
hw/rtl/grg_in_if.sv
hw/rtl/grg_front.sv
hw/rtl/grg_fifo.sv
hw/rtl/grg_back.sv
hw/rtl/givens_rotation_generator.sv
tb/tb_givens_rotation_generator.sv
